### design/assert_macros.svh
// Assertion macros shared by the compacting array store modules.
// No dependencies; defining ASSERT_OFF turns every assertion into nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// cond holds on every clock edge out of reset
`define ASSERT_HOLDS(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: invariant");

// trig in a cycle implies expr in that same cycle
`define ASSERT_IMPL(name, clk, rst_n, trig, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (expr)) \
    else $error("assertion failed: same-cycle implication");

// trig in a cycle implies expr in the next cycle
`define ASSERT_NEXT(name, clk, rst_n, trig, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_HOLDS(name, clk, rst_n, cond)
`define ASSERT_IMPL(name, clk, rst_n, trig, expr)
`define ASSERT_NEXT(name, clk, rst_n, trig, expr)

`endif

`endif

### design/cas_pkg.sv
// Types and codes for the compacting array store.
// No dependencies; used by cas_ctrl, cas_dpath and compacting_array_store.
package cas_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 8;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_DISPLAY = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_INSERTED = 3'd0,
    STAT_REMOVED  = 3'd1,
    STAT_INVALID  = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_ELEMENT  = 3'd4,
    STAT_EMPTY    = 3'd5
  } status_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic signed [DATA_W-1:0]  value;
    logic [IDX_W-1:0]          index;
  } in_item_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  element;
    logic [IDX_W-1:0]          position;
    logic                      last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SH_RD,
    ST_SH_WR,
    ST_DISP_RD,
    ST_DISP_EMIT
  } state_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NOP,
    OP_INSERT,
    OP_FULL,
    OP_INVALID,
    OP_SH_START,
    OP_SH_READ,
    OP_SH_WRITE,
    OP_REMOVED,
    OP_EMPTY,
    OP_DISP_START,
    OP_DISP_READ,
    OP_DISP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;        // count at capacity
    logic empty;       // count is zero
    logic idx_ok;      // incoming index below count
    logic shift_more;  // another entry sits above the shift pointer
    logic disp_last;   // pointer is at the final stored entry
  } dp_stat_t;

endpackage

### design/cas_dpath.sv
// Datapath of the compacting array store: entry memory, count, pointer, result register.
// Depends on cas_pkg and assert_macros.svh; driven by cas_ctrl commands.
`include "assert_macros.svh"

module cas_dpath #(
  parameter int CAPACITY = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cas_pkg::in_item_t    in_data,
  input  cas_pkg::ctrl_cmd_t   ctrl,
  output cas_pkg::dp_stat_t    stat,
  output logic                 out_valid,
  output cas_pkg::out_item_t   out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic signed [cas_pkg::DATA_W-1:0] entries_r [CAPACITY];
  logic signed [cas_pkg::DATA_W-1:0] rd_data_r;

  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               ptr_r, ptr_nxt;
  logic [CW-1:0]               ptr_inc;
  logic [cas_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic                        out_valid_r, out_valid_nxt;
  cas_pkg::out_item_t          out_data_r, out_data_nxt;

  logic                              mem_we, mem_re;
  logic [AW-1:0]                     mem_waddr, mem_raddr;
  logic signed [cas_pkg::DATA_W-1:0] mem_wdata;

  assign ptr_inc = ptr_r + CW'(1);

  assign stat.full       = (count_r == CW'(CAPACITY));
  assign stat.empty      = (count_r == '0);
  assign stat.idx_ok     = (in_data.index < cas_pkg::IDX_W'(count_r));
  assign stat.shift_more = (ptr_inc < count_r);
  assign stat.disp_last  = (ptr_inc == count_r);

  always_comb begin
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    mem_we        = 1'b0;
    mem_waddr     = count_r[AW-1:0];
    mem_wdata     = in_data.value;
    mem_re        = 1'b0;
    mem_raddr     = ptr_r[AW-1:0];
    case (ctrl.op)
      cas_pkg::OP_INSERT: begin
        mem_we                = 1'b1;
        count_nxt             = count_r + CW'(1);
        out_valid_nxt         = 1'b1;
        out_data_nxt.status   = cas_pkg::STAT_INSERTED;
        out_data_nxt.element  = in_data.value;
        out_data_nxt.position = cas_pkg::IDX_W'(count_r);
        out_data_nxt.last     = 1'b1;
      end
      cas_pkg::OP_FULL: begin
        out_valid_nxt       = 1'b1;
        out_data_nxt.status = cas_pkg::STAT_FULL;
        out_data_nxt.last   = 1'b1;
      end
      cas_pkg::OP_INVALID: begin
        out_valid_nxt         = 1'b1;
        out_data_nxt.status   = cas_pkg::STAT_INVALID;
        out_data_nxt.position = in_data.index;
        out_data_nxt.last     = 1'b1;
      end
      cas_pkg::OP_SH_START: begin
        ptr_nxt = CW'(in_data.index);
        idx_nxt = in_data.index;
      end
      cas_pkg::OP_SH_READ: begin
        mem_re    = 1'b1;
        mem_raddr = ptr_inc[AW-1:0];
      end
      cas_pkg::OP_SH_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r[AW-1:0];
        mem_wdata = rd_data_r;
        ptr_nxt   = ptr_inc;
      end
      cas_pkg::OP_REMOVED: begin
        count_nxt             = count_r - CW'(1);
        out_valid_nxt         = 1'b1;
        out_data_nxt.status   = cas_pkg::STAT_REMOVED;
        out_data_nxt.position = idx_r;
        out_data_nxt.last     = 1'b1;
      end
      cas_pkg::OP_EMPTY: begin
        out_valid_nxt       = 1'b1;
        out_data_nxt.status = cas_pkg::STAT_EMPTY;
        out_data_nxt.last   = 1'b1;
      end
      cas_pkg::OP_DISP_START: begin
        ptr_nxt = '0;
      end
      cas_pkg::OP_DISP_READ: begin
        mem_re = 1'b1;
      end
      cas_pkg::OP_DISP_EMIT: begin
        out_valid_nxt         = 1'b1;
        out_data_nxt.status   = cas_pkg::STAT_ELEMENT;
        out_data_nxt.element  = rd_data_r;
        out_data_nxt.position = cas_pkg::IDX_W'(ptr_r);
        out_data_nxt.last     = stat.disp_last;
        ptr_nxt               = ptr_inc;
      end
      default: begin
      end
    endcase
  end

  // single write port, single registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entries_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= entries_r[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_HOLDS(a_count_bound, clk, rst_n, count_r <= CW'(CAPACITY))
  `ASSERT_NEXT(a_full_keeps_count, clk, rst_n, ctrl.op == cas_pkg::OP_FULL, $stable(count_r))
  `ASSERT_NEXT(a_remove_drops_one, clk, rst_n, ctrl.op == cas_pkg::OP_REMOVED, count_r == $past(count_r) - CW'(1))
  `ASSERT_IMPL(a_last_elem_at_end, clk, rst_n, out_valid_r && out_data_r.status == cas_pkg::STAT_ELEMENT && out_data_r.last, ptr_r == count_r)

endmodule

### design/cas_ctrl.sv
// Controller state machine of the compacting array store.
// Depends on cas_pkg and assert_macros.svh; sequences cas_dpath operations.
`include "assert_macros.svh"

module cas_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  cas_pkg::cmd_t       in_cmd,
  input  cas_pkg::dp_stat_t   stat,
  output cas_pkg::ctrl_cmd_t  ctrl,
  output logic                busy
);

  cas_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cas_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl.op   = cas_pkg::OP_NOP;
    case (state_r)
      cas_pkg::ST_IDLE: begin
        if (start) begin
          case (in_cmd)
            cas_pkg::CMD_INSERT: begin
              ctrl.op = stat.full ? cas_pkg::OP_FULL : cas_pkg::OP_INSERT;
            end
            cas_pkg::CMD_REMOVE: begin
              if (stat.idx_ok) begin
                ctrl.op   = cas_pkg::OP_SH_START;
                state_nxt = cas_pkg::ST_SH_RD;
              end else begin
                ctrl.op = cas_pkg::OP_INVALID;
              end
            end
            cas_pkg::CMD_DISPLAY: begin
              if (stat.empty) begin
                ctrl.op = cas_pkg::OP_EMPTY;
              end else begin
                ctrl.op   = cas_pkg::OP_DISP_START;
                state_nxt = cas_pkg::ST_DISP_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      cas_pkg::ST_SH_RD: begin
        if (stat.shift_more) begin
          ctrl.op   = cas_pkg::OP_SH_READ;
          state_nxt = cas_pkg::ST_SH_WR;
        end else begin
          ctrl.op   = cas_pkg::OP_REMOVED;
          state_nxt = cas_pkg::ST_IDLE;
        end
      end
      cas_pkg::ST_SH_WR: begin
        ctrl.op   = cas_pkg::OP_SH_WRITE;
        state_nxt = cas_pkg::ST_SH_RD;
      end
      cas_pkg::ST_DISP_RD: begin
        ctrl.op   = cas_pkg::OP_DISP_READ;
        state_nxt = cas_pkg::ST_DISP_EMIT;
      end
      cas_pkg::ST_DISP_EMIT: begin
        ctrl.op   = cas_pkg::OP_DISP_EMIT;
        state_nxt = stat.disp_last ? cas_pkg::ST_IDLE : cas_pkg::ST_DISP_RD;
      end
      default: begin
        state_nxt = cas_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != cas_pkg::ST_IDLE);

  `ASSERT_NEXT(a_shift_read_then_write, clk, rst_n, ctrl.op == cas_pkg::OP_SH_READ, ctrl.op == cas_pkg::OP_SH_WRITE)
  `ASSERT_IMPL(a_item_ops_only_idle, clk, rst_n, ctrl.op == cas_pkg::OP_INSERT || ctrl.op == cas_pkg::OP_SH_START || ctrl.op == cas_pkg::OP_DISP_START, !busy && start)

endmodule

### design/compacting_array_store.sv
// Top level of the compacting array store: ordered store with insert, remove-at and display.
// Depends on cas_pkg, cas_ctrl and cas_dpath.
//
// An item is taken when start is high and busy is low. Results come out one
// at a time on out_data, each valid for exactly one cycle while out_valid is
// high; the receiver must take them as they come, there is no stall. Every
// item ends with a result that has last set, except the unused command code,
// which is dropped without a result. Sequencing, with n stored entries:
//   - insert (or refused insert on a full store), remove with an out-of-range
//     index, display of an empty store: result the next cycle.
//   - remove at index i: every later entry, up to entry n-1, moves down by
//     a read then a write through the registered read port of the entry memory.
//   - display: each element result is paced by the registered memory read
//     ahead of it; no new item is taken until the last element is emitted.
// Stored entries are held in a memory with no reset; only positions below
// the count are ever read, so no clearing pass runs after reset.
// CAPACITY sets the number of entries (1 to 255); an insert into a full store
// is refused with a full status and leaves the contents alone.

module compacting_array_store #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  cas_pkg::in_item_t   in_data,
  output logic                out_valid,
  output cas_pkg::out_item_t  out_data
);

  cas_pkg::ctrl_cmd_t ctrl;   // operation for this cycle
  cas_pkg::dp_stat_t  stat;   // count/pointer compares back to the FSM

  // sequencing: decodes the item at transfer, walks shifts and display
  cas_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_data.cmd),
    .stat   (stat),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  // storage, count, pointer and the registered result
  cas_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
